[rtl/cmp_pkg.sv]
// Shared types, widths and helpers for the 3x3 convolution / 3x3 max-pool core.
// Used by cmp_line, cmp_conv, cmp_pool and the top level; depends on nothing.
package cmp_pkg;

  localparam int unsigned PixW     = 16;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned RowSumW  = 34;
  localparam int unsigned SumW     = 36;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned QW       = 11;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned CoefRowW = 48;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned WinDim   = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutPadW  = OutDataW - SumW - 2 * IdxW;
  localparam int          MinImageSize = 5;

  localparam logic [SizeW-1:0]    SizeReset    = 7'd11;
  localparam logic [CoefRowW-1:0] CoefTopReset = 48'h0000_0000_0000;
  localparam logic [CoefRowW-1:0] CoefMidReset = 48'h0100_0100_0100;
  localparam logic [CoefRowW-1:0] CoefBotReset = 48'h0000_0000_0000;
  localparam logic [QW-1:0]       Recip3       = 11'd683;

  typedef enum logic [1:0] {
    RegImageSize,
    RegCoefTop,
    RegCoefMid,
    RegCoefBot
  } cmp_reg_e;

  typedef struct packed {
    logic            conv;
    logic            first;
    logic            emit;
    logic            last;
    logic [IdxW-1:0] pr;
    logic [QW-1:0]   pc;
  } cmp_tag_t;

  typedef struct packed {
    logic            last;
    logic [IdxW-1:0] col;
    logic [IdxW-1:0] row;
    logic [SumW-1:0] max;
  } cmp_result_t;

  // floor(x/3), exact for every x below 2048
  function automatic logic [QW-1:0] div3(input logic [QW-1:0] x);
    logic [2*QW-1:0] prod;
    prod = {{QW{1'b0}}, x} * {{QW{1'b0}}, Recip3};
    return prod[2*QW-1:QW];
  endfunction

  function automatic logic [1:0] mod3(input logic [QW-1:0] x, input logic [QW-1:0] q);
    logic [QW-1:0] rem;
    rem = x - (q + (q << 1));
    return rem[1:0];
  endfunction

endpackage

[rtl/cmp_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module cmp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cmp_line.sv]
// Raster position counters, two-line pixel store with read-modify-write and pool decode.
// Depends on cmp_pkg and cmp_ram.
module cmp_line #(
  parameter int unsigned MAX_IMAGE_SIZE = 64,
  localparam int unsigned CW = $clog2(MAX_IMAGE_SIZE + 1),
  localparam int unsigned AW = $clog2(MAX_IMAGE_SIZE)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        accept_i,
  input  logic [cmp_pkg::PixW-1:0]    pixel_i,
  input  logic                        frame_start_i,
  input  logic [CW-1:0]               size_i,
  output logic                        valid_o,
  output logic [cmp_pkg::PixW-1:0]    pixel_o,
  output logic [cmp_pkg::PixW-1:0]    line_top_o,
  output logic [cmp_pkg::PixW-1:0]    line_mid_o,
  output cmp_pkg::cmp_tag_t           tag_o
);

  localparam int unsigned LineW = 2 * cmp_pkg::PixW;

  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [CW-1:0] row0, col0;
  logic          v1_q;
  logic [CW-1:0] r1_q, c1_q;
  logic [cmp_pkg::PixW-1:0] px1_q;

  logic [LineW-1:0] rdata, line_data, wdata;
  logic             fwd_valid_q;
  logic [AW-1:0]    fwd_addr_q;
  logic [LineW-1:0] fwd_data_q;

  logic [cmp_pkg::QW-1:0] rx, cx, nx, cr, cc, p, pr, pc;
  logic                   conv;

  always_comb begin
    row0 = frame_start_i ? '0 : row_q;
    col0 = frame_start_i ? '0 : col_q;
    if (col0 >= size_i) begin
      col0 = '0;
      row0 = row0 + CW'(1);
    end
    if (row0 >= size_i) begin
      row0 = '0;
    end
    if (col0 + CW'(1) >= size_i) begin
      col_d = '0;
      row_d = (row0 + CW'(1) >= size_i) ? '0 : row0 + CW'(1);
    end else begin
      col_d = col0 + CW'(1);
      row_d = row0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      v1_q        <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else if (en_i) begin
      if (accept_i) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      v1_q        <= accept_i;
      fwd_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q       <= row0;
      c1_q       <= col0;
      px1_q      <= pixel_i;
      fwd_addr_q <= c1_q[AW-1:0];
      fwd_data_q <= wdata;
    end
  end

  cmp_ram #(
    .Width (LineW),
    .Depth (MAX_IMAGE_SIZE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (en_i & v1_q),
    .waddr_i (c1_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (en_i),
    .raddr_i (col0[AW-1:0]),
    .rdata_o (rdata)
  );

  assign line_data  = (fwd_valid_q && fwd_addr_q == c1_q[AW-1:0]) ? fwd_data_q : rdata;
  assign wdata      = {px1_q, line_data[LineW-1:cmp_pkg::PixW]};
  assign line_top_o = line_data[cmp_pkg::PixW-1:0];
  assign line_mid_o = line_data[LineW-1:cmp_pkg::PixW];
  assign pixel_o    = px1_q;
  assign valid_o    = v1_q;

  always_comb begin
    rx   = cmp_pkg::QW'(r1_q);
    cx   = cmp_pkg::QW'(c1_q);
    nx   = cmp_pkg::QW'(size_i);
    cr   = rx - cmp_pkg::QW'(2);
    cc   = cx - cmp_pkg::QW'(2);
    p    = cmp_pkg::div3(nx - cmp_pkg::QW'(2));
    pr   = cmp_pkg::div3(cr);
    pc   = cmp_pkg::div3(cc);
    conv = v1_q && (rx >= cmp_pkg::QW'(2)) && (cx >= cmp_pkg::QW'(2)) && (pr < p) && (pc < p);
    tag_o.conv  = conv;
    tag_o.first = conv && (cmp_pkg::mod3(cr, pr) == 2'd0) && (cmp_pkg::mod3(cc, pc) == 2'd0);
    tag_o.emit  = conv && (cmp_pkg::mod3(cr, pr) == 2'd2) && (cmp_pkg::mod3(cc, pc) == 2'd2);
    tag_o.last  = (pr == p - cmp_pkg::QW'(1)) && (pc == p - cmp_pkg::QW'(1));
    tag_o.pr    = pr[cmp_pkg::IdxW-1:0];
    tag_o.pc    = pc;
  end

endmodule

[rtl/cmp_conv.sv]
// 3x3 pixel window and pipelined multiply-accumulate of the convolution.
// Depends on cmp_pkg.
module cmp_conv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [cmp_pkg::PixW-1:0]            line_top_i,
  input  logic [cmp_pkg::PixW-1:0]            line_mid_i,
  input  logic [cmp_pkg::PixW-1:0]            pixel_i,
  input  cmp_pkg::cmp_tag_t                   tag_i,
  input  logic [cmp_pkg::CoefRowW-1:0]        coef_top_i,
  input  logic [cmp_pkg::CoefRowW-1:0]        coef_mid_i,
  input  logic [cmp_pkg::CoefRowW-1:0]        coef_bot_i,
  output cmp_pkg::cmp_tag_t                   pre_tag_o,
  output cmp_pkg::cmp_tag_t                   tag_o,
  output logic signed [cmp_pkg::SumW-1:0]     sum_o
);

  localparam int unsigned D = cmp_pkg::WinDim;

  logic signed [cmp_pkg::PixW-1:0]    win_q  [D][D];
  logic signed [cmp_pkg::ProdW-1:0]   prod_q [D][D];
  logic signed [cmp_pkg::RowSumW-1:0] row_q  [D];
  logic signed [cmp_pkg::SumW-1:0]    sum_q;
  logic [cmp_pkg::CoefRowW-1:0]       coef_rows [D];
  cmp_pkg::cmp_tag_t                  t_win_q, t_prod_q, t_row_q, t_sum_q;

  assign coef_rows[0] = coef_top_i;
  assign coef_rows[1] = coef_mid_i;
  assign coef_rows[2] = coef_bot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < D; m++) begin
        for (int k = 0; k < D; k++) begin
          win_q[m][k] <= '0;
        end
      end
      t_win_q  <= '0;
      t_prod_q <= '0;
      t_row_q  <= '0;
      t_sum_q  <= '0;
    end else if (en_i) begin
      if (valid_i) begin
        for (int m = 0; m < D; m++) begin
          win_q[m][0] <= win_q[m][1];
          win_q[m][1] <= win_q[m][2];
        end
        win_q[0][2] <= line_top_i;
        win_q[1][2] <= line_mid_i;
        win_q[2][2] <= pixel_i;
      end
      t_win_q  <= tag_i;
      t_prod_q <= t_win_q;
      t_row_q  <= t_prod_q;
      t_sum_q  <= t_row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int m = 0; m < D; m++) begin
        for (int k = 0; k < D; k++) begin
          prod_q[m][k] <= win_q[m][k]
                          * $signed(coef_rows[m][k*cmp_pkg::PixW +: cmp_pkg::PixW]);
        end
        row_q[m] <= cmp_pkg::RowSumW'(prod_q[m][0]) + cmp_pkg::RowSumW'(prod_q[m][1])
                    + cmp_pkg::RowSumW'(prod_q[m][2]);
      end
      sum_q <= cmp_pkg::SumW'(row_q[0]) + cmp_pkg::SumW'(row_q[1])
               + cmp_pkg::SumW'(row_q[2]);
    end
  end

  assign pre_tag_o = t_row_q;
  assign tag_o     = t_sum_q;
  assign sum_o     = sum_q;

endmodule

[rtl/cmp_pool.sv]
// Running maximum per pool column of the current band, kept in a RAM with forwarding.
// Depends on cmp_pkg and cmp_ram.
module cmp_pool #(
  parameter int unsigned MAX_IMAGE_SIZE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  cmp_pkg::cmp_tag_t               rd_tag_i,
  input  cmp_pkg::cmp_tag_t               tag_i,
  input  logic signed [cmp_pkg::SumW-1:0] sum_i,
  output logic                            push_o,
  output cmp_pkg::cmp_result_t            result_o
);

  localparam int unsigned BandDepth = MAX_IMAGE_SIZE / 3 + 1;
  localparam int unsigned BAW       = $clog2(BandDepth);

  logic signed [cmp_pkg::SumW-1:0] rdata, old_max, new_max;
  logic                            fwd_valid_q;
  logic [BAW-1:0]                  fwd_addr_q;
  logic signed [cmp_pkg::SumW-1:0] fwd_data_q;

  cmp_ram #(
    .Width (cmp_pkg::SumW),
    .Depth (BandDepth)
  ) u_band_ram (
    .clk_i   (clk_i),
    .we_i    (en_i & tag_i.conv),
    .waddr_i (tag_i.pc[BAW-1:0]),
    .wdata_i (new_max),
    .re_i    (en_i),
    .raddr_i (rd_tag_i.pc[BAW-1:0]),
    .rdata_o (rdata)
  );

  assign old_max = (fwd_valid_q && fwd_addr_q == tag_i.pc[BAW-1:0]) ? fwd_data_q : rdata;
  assign new_max = (tag_i.first || sum_i > old_max) ? sum_i : old_max;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (en_i) begin
      fwd_valid_q <= tag_i.conv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fwd_addr_q <= tag_i.pc[BAW-1:0];
      fwd_data_q <= new_max;
    end
  end

  assign push_o          = en_i & tag_i.emit;
  assign result_o.last   = tag_i.last;
  assign result_o.col    = tag_i.pc[cmp_pkg::IdxW-1:0];
  assign result_o.row    = tag_i.pr;
  assign result_o.max    = new_max;

endmodule

[rtl/conv3x3_maxpool3x3_core.sv]
// Top level of the 3x3 valid convolution with 3x3 stride-3 max pooling.
// Depends on cmp_pkg, cmp_line, cmp_conv, cmp_pool and cmp_ram.
//
// The core takes one Q8.8 pixel per clock in raster order and, for every whole
// 3x3 pool window of the interior convolution plane, returns the window maximum
// in Q20.16 with its pool row and column; tlast marks the last window of a
// frame. Two line memories share one RAM of MAX_IMAGE_SIZE words read and
// written once per pixel, and the band maxima sit in a second RAM read and
// written once per convolution value; both forward the previous write so
// consecutive updates of one entry see each other. Results pass through a
// two-entry output queue: s_axis_tready drops only while two results wait
// unread, so with m_axis_tready held high the core sustains one pixel per
// cycle. Memories need no clearing after reset.
// Registers (64-bit APB, 8-byte stride): image_size, coef_row_top,
// coef_row_mid, coef_row_bottom; write them only while the core is idle.
module conv3x3_maxpool3x3_core #(
  parameter int unsigned MAX_IMAGE_SIZE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cmp_pkg::InDataW-1:0]     s_axis_tdata,  // [15:0] pixel
  input  logic                            s_axis_tuser,  // [0] frame_start
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [35:0] pooled_max, [40:36] pool_row, [45:41] pool_col, [47:46] zero
  output logic [cmp_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmp_pkg::CfgAddrW-1:0]    paddr,
  input  logic [cmp_pkg::CfgDataW-1:0]    pwdata,
  output logic [cmp_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned CW = $clog2(MAX_IMAGE_SIZE + 1);
  localparam logic [1:0]  QueueDepth = 2'd2;

  logic [cmp_pkg::SizeW-1:0]    image_size_q;
  logic [cmp_pkg::CoefRowW-1:0] coef_top_q, coef_mid_q, coef_bot_q;
  cmp_pkg::cmp_reg_e            cfg_idx;
  logic                         cfg_we;
  logic [CW-1:0]                size;

  logic                         en, accept;
  logic                         v1;
  logic [cmp_pkg::PixW-1:0]     px1, line_top, line_mid;
  cmp_pkg::cmp_tag_t            tag1, pre_tag, sum_tag;
  logic signed [cmp_pkg::SumW-1:0] sum;
  logic                         push, pop;
  cmp_pkg::cmp_result_t         result, head;

  cmp_pkg::cmp_result_t         queue_q [2];
  logic                         wr_ptr_q, rd_ptr_q;
  logic [1:0]                   count_q, count_d;

  // Configuration port
  assign cfg_idx = cmp_pkg::cmp_reg_e'(paddr[cmp_pkg::CfgAddrW-1:3]);
  assign cfg_we  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= cmp_pkg::SizeReset;
      coef_top_q   <= cmp_pkg::CoefTopReset;
      coef_mid_q   <= cmp_pkg::CoefMidReset;
      coef_bot_q   <= cmp_pkg::CoefBotReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        cmp_pkg::RegImageSize: image_size_q <= pwdata[cmp_pkg::SizeW-1:0];
        cmp_pkg::RegCoefTop:   coef_top_q   <= pwdata[cmp_pkg::CoefRowW-1:0];
        cmp_pkg::RegCoefMid:   coef_mid_q   <= pwdata[cmp_pkg::CoefRowW-1:0];
        cmp_pkg::RegCoefBot:   coef_bot_q   <= pwdata[cmp_pkg::CoefRowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cmp_pkg::RegImageSize: prdata = cmp_pkg::CfgDataW'(image_size_q);
      cmp_pkg::RegCoefTop:   prdata = cmp_pkg::CfgDataW'(coef_top_q);
      cmp_pkg::RegCoefMid:   prdata = cmp_pkg::CfgDataW'(coef_mid_q);
      cmp_pkg::RegCoefBot:   prdata = cmp_pkg::CfgDataW'(coef_bot_q);
      default:               prdata = '0;
    endcase
  end

  // Clamp the image side into the supported range
  always_comb begin
    if (int'(image_size_q) < cmp_pkg::MinImageSize) begin
      size = CW'(cmp_pkg::MinImageSize);
    end else if (int'(image_size_q) > int'(MAX_IMAGE_SIZE)) begin
      size = CW'(MAX_IMAGE_SIZE);
    end else begin
      size = CW'(image_size_q);
    end
  end

  assign en            = (count_q != QueueDepth);
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid & en;

  cmp_line #(
    .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
  ) u_line (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .accept_i      (accept),
    .pixel_i       (s_axis_tdata[cmp_pkg::PixW-1:0]),
    .frame_start_i (s_axis_tuser),
    .size_i        (size),
    .valid_o       (v1),
    .pixel_o       (px1),
    .line_top_o    (line_top),
    .line_mid_o    (line_mid),
    .tag_o         (tag1)
  );

  cmp_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v1),
    .line_top_i (line_top),
    .line_mid_i (line_mid),
    .pixel_i    (px1),
    .tag_i      (tag1),
    .coef_top_i (coef_top_q),
    .coef_mid_i (coef_mid_q),
    .coef_bot_i (coef_bot_q),
    .pre_tag_o  (pre_tag),
    .tag_o      (sum_tag),
    .sum_o      (sum)
  );

  cmp_pool #(
    .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
  ) u_pool (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .rd_tag_i (pre_tag),
    .tag_i    (sum_tag),
    .sum_i    (sum),
    .push_o   (push),
    .result_o (result)
  );

  // Output queue
  assign pop  = m_axis_tvalid & m_axis_tready;
  assign head = queue_q[rd_ptr_q];

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= result;
    end
  end

  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {{cmp_pkg::OutPadW{1'b0}}, head.col, head.row, head.max};
  assign m_axis_tlast  = head.last;

endmodule

[rtl/cmp_checker.sv]
// Port-level assertions for the convolution / max-pool core, bound to its top level.
// Depends on conv3x3_maxpool3x3_core.
module cmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result request changed while stalled");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_stall_after_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  a_last_on_diagonal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[40:36] == m_axis_tdata[45:41])
    else $error("last pool window is not on the diagonal");

endmodule

bind conv3x3_maxpool3x3_core cmp_checker u_cmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/tb_conv3x3_maxpool3x3_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_maxpool3x3_core: random raster pixel streams, APB setup,
// and a scoreboard that predicts every pooled maximum. Depends on cmp_pkg and the core RTL.
module tb_conv3x3_maxpool3x3_core;

  localparam int unsigned MaxSide      = 64;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 12;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [cmp_pkg::InDataW-1:0]   s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [cmp_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [cmp_pkg::CfgAddrW-1:0]  paddr;
  logic [cmp_pkg::CfgDataW-1:0]  pwdata;
  logic [cmp_pkg::CfgDataW-1:0]  prdata;
  logic                          pready;

  bit gaps_on;
  bit hold_req;

  conv3x3_maxpool3x3_core #(
    .MAX_IMAGE_SIZE(MaxSide)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  class pool_scoreboard;
    typedef struct {
      logic [cmp_pkg::SumW-1:0] max;
      logic [cmp_pkg::IdxW-1:0] row;
      logic [cmp_pkg::IdxW-1:0] col;
      logic                     last;
    } pooled_t;

    logic [cmp_pkg::SizeW-1:0]       size_reg;
    logic [cmp_pkg::CoefRowW-1:0]    coef_rows[3];
    logic signed [cmp_pkg::PixW-1:0] line_buf[2][MaxSide];
    logic signed [cmp_pkg::PixW-1:0] win[3][3];
    longint                          band_max[MaxSide/3+1];
    int unsigned                     row;
    int unsigned                     col;
    pooled_t                         pending_q[$];
    int                              n_err;

    function new();
      size_reg     = cmp_pkg::SizeReset;
      coef_rows[0] = cmp_pkg::CoefTopReset;
      coef_rows[1] = cmp_pkg::CoefMidReset;
      coef_rows[2] = cmp_pkg::CoefBotReset;
      foreach (line_buf[i, j]) line_buf[i][j] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (band_max[i]) band_max[i] = 0;
      row   = 0;
      col   = 0;
      n_err = 0;
    endfunction

    function int unsigned side();
      if (size_reg < cmp_pkg::MinImageSize) return cmp_pkg::MinImageSize;
      if (size_reg > MaxSide) return MaxSide;
      return size_reg;
    endfunction

    function void write_reg(cmp_pkg::cmp_reg_e idx, logic [cmp_pkg::CfgDataW-1:0] val);
      case (idx)
        cmp_pkg::RegImageSize: size_reg = val[cmp_pkg::SizeW-1:0];
        cmp_pkg::RegCoefTop:   coef_rows[0] = val[cmp_pkg::CoefRowW-1:0];
        cmp_pkg::RegCoefMid:   coef_rows[1] = val[cmp_pkg::CoefRowW-1:0];
        cmp_pkg::RegCoefBot:   coef_rows[2] = val[cmp_pkg::CoefRowW-1:0];
        default:               ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void note_pixel(logic [cmp_pkg::PixW-1:0] pix, logic fs);
      int unsigned n, r, c, p, pr, pc;
      longint acc;
      logic signed [cmp_pkg::PixW-1:0] cf;
      pooled_t res;
      n = side();
      if (fs) begin
        row = 0;
        col = 0;
      end
      if (col >= n) begin
        col = 0;
        row++;
      end
      if (row >= n) row = 0;
      r = row;
      c = col;
      for (int m = 0; m < 3; m++) begin
        win[m][0] = win[m][1];
        win[m][1] = win[m][2];
      end
      win[0][2] = line_buf[0][c];
      win[1][2] = line_buf[1][c];
      win[2][2] = pix;
      line_buf[0][c] = line_buf[1][c];
      line_buf[1][c] = pix;
      if (r >= 2 && c >= 2) begin
        p  = (n - 2) / 3;
        pr = (r - 2) / 3;
        pc = (c - 2) / 3;
        if (pr < p && pc < p) begin
          acc = 0;
          for (int m = 0; m < 3; m++) begin
            for (int k = 0; k < 3; k++) begin
              cf = coef_rows[m][16*k +: 16];
              acc += longint'(win[m][k]) * longint'(cf);
            end
          end
          if ((r - 2) % 3 == 0 && (c - 2) % 3 == 0) begin
            band_max[pc] = acc;
          end else if (acc > band_max[pc]) begin
            band_max[pc] = acc;
          end
          if ((r - 2) % 3 == 2 && (c - 2) % 3 == 2) begin
            res.max  = cmp_pkg::SumW'(band_max[pc]);
            res.row  = cmp_pkg::IdxW'(pr);
            res.col  = cmp_pkg::IdxW'(pc);
            res.last = (pr == p - 1 && pc == p - 1);
            pending_q.push_back(res);
          end
        end
      end
      // advance the raster position
      if (c + 1 >= n) begin
        col = 0;
        row = (r + 1 >= n) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    task report_mismatch(string what);
      if (n_err < 50) $display("%0t ns: mismatch: %s", $time, what);
      n_err++;
    endtask

    task check_pooled(logic [cmp_pkg::OutDataW-1:0] data, logic last);
      pooled_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("pooled result %h last %b with none pending", data, last));
        return;
      end
      want = pending_q.pop_front();
      if (data[cmp_pkg::SumW-1:0] !== want.max)
        report_mismatch($sformatf("pooled max %h, expected %h (row %0d col %0d)",
                                  data[cmp_pkg::SumW-1:0], want.max, want.row, want.col));
      if (data[cmp_pkg::SumW +: cmp_pkg::IdxW] !== want.row)
        report_mismatch($sformatf("pool row %0d, expected %0d",
                                  data[cmp_pkg::SumW +: cmp_pkg::IdxW], want.row));
      if (data[cmp_pkg::SumW+cmp_pkg::IdxW +: cmp_pkg::IdxW] !== want.col)
        report_mismatch($sformatf("pool col %0d, expected %0d",
                                  data[cmp_pkg::SumW+cmp_pkg::IdxW +: cmp_pkg::IdxW],
                                  want.col));
      if (data[cmp_pkg::OutDataW-1:cmp_pkg::SumW+2*cmp_pkg::IdxW] !== '0)
        report_mismatch($sformatf("pad bits %b not zero",
                                  data[cmp_pkg::OutDataW-1:cmp_pkg::SumW+2*cmp_pkg::IdxW]));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, expected %b (row %0d col %0d)", last, want.last,
                                  want.row, want.col));
    endtask
  endclass

  pool_scoreboard sb;

  function automatic logic [15:0] pick_word();
    case ($urandom_range(19))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [cmp_pkg::CfgDataW-1:0] coef_word();
    return {16'($urandom), pick_word(), pick_word(), pick_word()};
  endfunction

  task automatic send_pixel(logic [cmp_pkg::PixW-1:0] pix, logic fs);
    while (gaps_on && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(pix, fs);
  endtask

  task automatic send_run(int unsigned count, bit fs_first);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_word(), fs_first && i == 0);
  endtask

  // hold until every pooled result is back and the pipeline has gone quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_check(cmp_pkg::cmp_reg_e idx, logic [cmp_pkg::CfgDataW-1:0] want);
    logic [cmp_pkg::CfgDataW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== want)
      sb.report_mismatch($sformatf("register %s reads %h, expected %h", idx.name(), got, want));
  endtask

  task automatic cfg_write(cmp_pkg::cmp_reg_e idx, logic [cmp_pkg::CfgDataW-1:0] val);
    logic [cmp_pkg::CfgDataW-1:0] want;
    want = (idx == cmp_pkg::RegImageSize) ? cmp_pkg::CfgDataW'(val[cmp_pkg::SizeW-1:0])
                                          : cmp_pkg::CfgDataW'(val[cmp_pkg::CoefRowW-1:0]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    cfg_check(idx, want);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_pooled(m_axis_tdata, m_axis_tlast);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= !gaps_on || $urandom_range(99) >= 31;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned n, count, kind, nframes, phase_idx, rand_items;
    logic [cmp_pkg::SizeW-1:0] size;
    logic [cmp_pkg::PixW-1:0] pix;
    bit fs_first, big_done;
    sb = new();
    gaps_on  = 1'b1;
    hold_req = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_check(cmp_pkg::RegImageSize, cmp_pkg::CfgDataW'(cmp_pkg::SizeReset));
    cfg_check(cmp_pkg::RegCoefTop, cmp_pkg::CfgDataW'(cmp_pkg::CoefTopReset));
    cfg_check(cmp_pkg::RegCoefMid, cmp_pkg::CfgDataW'(cmp_pkg::CoefMidReset));
    cfg_check(cmp_pkg::RegCoefBot, cmp_pkg::CfgDataW'(cmp_pkg::CoefBotReset));

    // smallest image, all coefficients at the negative extreme
    cfg_write(cmp_pkg::RegImageSize, 64'hFFFF_FFFF_FFFF_FF80);
    cfg_write(cmp_pkg::RegCoefTop, 64'hA5A5_8000_8000_8000);
    cfg_write(cmp_pkg::RegCoefMid, 64'h5A5A_8000_8000_8000);
    cfg_write(cmp_pkg::RegCoefBot, 64'hFFFF_8000_8000_8000);
    for (int i = 0; i < 25; i++) begin
      pix = (i == 24) ? 16'h7FFF : (i == 4) ? 16'h0000 : (i == 20) ? 16'hFFFF : 16'h8000;
      send_pixel(pix, i == 0);
    end

    phase_idx  = 0;
    big_done   = 1'b0;
    rand_items = 0;
    while (phase_idx < 3 || rand_items < 400) begin
      drain();
      if (phase_idx == 1) begin
        // largest image, first five rows back to back, no idling on either side
        cfg_write(cmp_pkg::RegImageSize, {57'($urandom), 7'h7F});
        gaps_on = 1'b0;
        send_run(5 * MaxSide, 1'b1);
        gaps_on  = 1'b1;
        big_done = 1'b1;
      end else begin
        kind = $urandom_range(99);
        if (phase_idx == 2) size = 7'd8;
        else if (kind < 10) size = cmp_pkg::SizeW'($urandom_range(0, 4));
        else if (kind < 20) size = cmp_pkg::SizeW'($urandom_range(13, 20));
        else size = cmp_pkg::SizeW'($urandom_range(5, 12));
        cfg_write(cmp_pkg::RegImageSize, {57'($urandom), size});
        for (int i = cmp_pkg::RegCoefTop; i <= cmp_pkg::RegCoefBot; i++) begin
          if ($urandom_range(9) < 7) cfg_write(cmp_pkg::cmp_reg_e'(i), coef_word());
        end
        n = sb.side();
        nframes = (phase_idx == 2) ? 3 : $urandom_range(1, 3);
        if (phase_idx == 2) hold_req = 1'b1;
        for (int f = 0; f < nframes; f++) begin
          kind = (phase_idx == 2) ? 99 : $urandom_range(99);
          fs_first = !(kind >= 15 && kind < 45 && (f > 0 || big_done));
          count = (kind < 15) ? $urandom_range(1, n * n - 1) : n * n;
          send_run(count, fs_first);
          rand_items += count;
        end
      end
      phase_idx++;
    end

    drain();
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
